// ----- sv/dbpc4d_pkg.sv -----
// ----------------------------------------------------------------------------
// dbpc4d_pkg
// Shared types and constants of the 4D point cloud density clustering unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dbpc4d_pkg;

    localparam int POINTS_DEF = 64;
    localparam int COORD_W    = 16;
    localparam int EPS_W      = 16;
    localparam int MINS_W     = 8;
    localparam int WGT_W      = 12;
    localparam int IDX_OUT_W  = 6;
    localparam int LABEL_W    = 7;
    localparam int CCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WGT  = 2'd2;

    localparam logic [EPS_W-1:0]  EPS_RST  = 16'd256;
    localparam logic [MINS_W-1:0] MINS_RST = 8'd5;
    localparam logic [WGT_W-1:0]  WGT_RST  = 12'd256;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    localparam logic [LABEL_W-1:0] NOISE_LABEL = 7'h7F;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] radial_speed;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_x;
    } item_t;

    typedef struct packed {
        logic [EPS_W-1:0]  eps_radius;
        logic [MINS_W-1:0] min_pts;
        logic [WGT_W-1:0]  doppler_weight;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/dbpc4d_ram.sv -----
// ----------------------------------------------------------------------------
// dbpc4d_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpc4d_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/dbpc4d_front.sv -----
// ----------------------------------------------------------------------------
// dbpc4d_front
// Command intake: accepts load and run commands into a two entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpc4d_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                command,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0] pos_y,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0] pos_z,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0] radial_speed,
    output logic                                     q_valid,
    output dbpc4d_pkg::item_t                        q_item,
    input  wire logic                                q_pop
);

    import dbpc4d_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{command: command, radial_speed: radial_speed,
                                      pos_z: pos_z, pos_y: pos_y, pos_x: pos_x};
        end
    end

endmodule

`default_nettype wire

// ----- sv/dbpc4d_back.sv -----
// ----------------------------------------------------------------------------
// dbpc4d_back
// Clustering engine: point store, adjacency build, cluster expansion, output.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpc4d_back #(
    parameter int MAX_POINTS = dbpc4d_pkg::POINTS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire dbpc4d_pkg::cfg_t                       cfg,
    input  wire logic                                   q_valid,
    input  wire dbpc4d_pkg::item_t                      q_item,
    output logic                                        q_pop,
    output logic                                        result_valid,
    output logic        [dbpc4d_pkg::IDX_OUT_W-1:0]     point_index,
    output logic signed [dbpc4d_pkg::LABEL_W-1:0]       cluster_label,
    output logic                                        point_valid,
    output logic        [dbpc4d_pkg::CCOUNT_W-1:0]      cluster_count,
    output logic                                        overflowed,
    output logic                                        is_last
);

    import dbpc4d_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 4 * COORD_W;
    localparam int ADJ_W = MAX_POINTS + CNT_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADJ_LDI   = 4'd1;
    localparam logic [3:0] S_ADJ_GETI  = 4'd2;
    localparam logic [3:0] S_ADJ_ISSUE = 4'd3;
    localparam logic [3:0] S_ADJ_DRAIN = 4'd4;
    localparam logic [3:0] S_SEED      = 4'd5;
    localparam logic [3:0] S_SEED_CHK  = 4'd6;
    localparam logic [3:0] S_POP       = 4'd7;
    localparam logic [3:0] S_POP_CHK   = 4'd8;
    localparam logic [3:0] S_LABEL     = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;
    localparam logic [3:0] S_OUT_TAIL  = 4'd11;

    function automatic logic [IDX_W-1:0] first_set(input logic [MAX_POINTS-1:0] m);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int b = MAX_POINTS - 1; b >= 0; b--)
        begin
            if (m[b])
            begin
                r = IDX_W'(b);
            end
        end
        return r;
    endfunction

    // control state
    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [MAX_POINTS-1:0] row_reg, row_next;
    logic [CNT_W-1:0]      nb_reg, nb_next;
    logic [MAX_POINTS-1:0] visited_reg, visited_next;
    logic [MAX_POINTS-1:0] pending_reg, pending_next;
    logic [MAX_POINTS-1:0] labeled_reg, labeled_next;
    logic [MAX_POINTS-1:0] newly_reg, newly_next;
    logic [CCOUNT_W-1:0]   clus_reg, clus_next;
    logic [2*EPS_W-1:0]    eps2_reg, eps2_next;
    logic [PT_W-1:0]       pi_reg, pi_next;

    // distance pipeline
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0]      j1_reg, j2_reg, j3_reg, j4_reg, j5_reg;
    logic signed [16:0]    dx_reg, dy_reg, dz_reg, dv_reg;
    logic [32:0]           sx_reg, sy_reg, sz_reg;
    logic signed [29:0]    dvw_reg;
    logic [34:0]           sum3_reg;
    logic [59:0]           dvw2_reg;
    logic [59:0]           tot_reg;
    logic signed [33:0]    px, py, pz;
    logic signed [29:0]    pdvw;
    logic signed [59:0]    pdvw2;
    logic                  hit;

    // readout
    logic                  rv_reg;
    logic [IDX_W-1:0]      rk_reg;

    // result registers
    logic                  res_valid_reg, res_valid_next;
    logic [IDX_OUT_W-1:0]  res_idx_reg, res_idx_next;
    logic [LABEL_W-1:0]    res_label_reg, res_label_next;
    logic                  res_pvalid_reg, res_pvalid_next;
    logic [CCOUNT_W-1:0]   res_ccount_reg, res_ccount_next;
    logic                  res_ovf_reg, res_ovf_next;
    logic                  res_last_reg, res_last_next;

    // memories
    logic                  st_we;
    logic [IDX_W-1:0]      st_raddr;
    logic [PT_W-1:0]       st_rdata;
    logic                  adj_we;
    logic [IDX_W-1:0]      adj_raddr;
    logic [ADJ_W-1:0]      adj_rdata;
    logic                  lab_we;
    logic [IDX_W-1:0]      lab_waddr;
    logic [LABEL_W-1:0]    lab_rdata;

    logic [IDX_W-1:0]      i_idx;
    logic [IDX_W-1:0]      j_idx;
    logic [CNT_W-1:0]      n_last;
    logic [MAX_POINTS-1:0] i_bit;
    logic [IDX_W-1:0]      pend_first;
    logic [MAX_POINTS-1:0] adj_row;
    logic [CNT_W-1:0]      adj_nb;
    logic                  adj_core;
    logic                  pipe_busy;

    assign i_idx      = i_reg[IDX_W-1:0];
    assign j_idx      = j_reg[IDX_W-1:0];
    assign n_last     = n_reg - CNT_W'(1);
    assign i_bit      = MAX_POINTS'(1) << i_idx;
    assign pend_first = first_set(pending_reg);
    assign adj_row    = adj_rdata[MAX_POINTS-1:0];
    assign adj_nb     = adj_rdata[MAX_POINTS +: CNT_W];
    assign adj_core   = (9'(adj_nb) + 9'd1) >= {1'b0, cfg.min_pts};
    assign pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign hit        = v5_reg && (j5_reg != i_idx) &&
                        (tot_reg <= {12'b0, eps2_reg, 16'b0});

    assign q_pop      = (state_reg == S_IDLE) && q_valid;

    assign st_we      = q_pop && (q_item.command == CMD_LOAD) &&
                        (count_reg < CNT_W'(MAX_POINTS));
    assign st_raddr   = (state_reg == S_ADJ_LDI) ? i_idx : j_idx;
    assign adj_we     = (state_reg == S_ADJ_DRAIN) && !pipe_busy;
    assign adj_raddr  = (state_reg == S_SEED) ? i_idx : pend_first;
    assign lab_we     = (state_reg == S_LABEL) && (newly_reg != '0);
    assign lab_waddr  = first_set(newly_reg);

    dbpc4d_ram #(
        .WIDTH  (PT_W),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({q_item.radial_speed, q_item.pos_z, q_item.pos_y, q_item.pos_x}),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dbpc4d_ram #(
        .WIDTH  (ADJ_W),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W)
    ) u_adj (
        .clk   (clk),
        .we    (adj_we),
        .waddr (i_idx),
        .wdata ({nb_reg, row_reg}),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dbpc4d_ram #(
        .WIDTH  (LABEL_W),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W)
    ) u_label (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (clus_reg),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (lab_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        row_next     = row_reg;
        nb_next      = nb_reg;
        visited_next = visited_reg;
        pending_next = pending_reg;
        labeled_next = labeled_reg;
        newly_next   = newly_reg;
        clus_next    = clus_reg;
        eps2_next    = eps2_reg;
        pi_next      = pi_reg;

        res_valid_next  = 1'b0;
        res_idx_next    = res_idx_reg;
        res_label_next  = res_label_reg;
        res_pvalid_next = res_pvalid_reg;
        res_ccount_next = res_ccount_reg;
        res_ovf_next    = res_ovf_reg;
        res_last_next   = res_last_reg;

        // accumulate neighbor hits as they leave the distance pipeline
        if (hit)
        begin
            row_next[j5_reg] = 1'b1;
            nb_next          = nb_reg + CNT_W'(1);
        end

        // result beat from the label readout
        if (rv_reg)
        begin
            res_valid_next  = 1'b1;
            res_idx_next    = IDX_OUT_W'(rk_reg);
            res_label_next  = labeled_reg[rk_reg] ? lab_rdata : NOISE_LABEL;
            res_pvalid_next = 1'b1;
            res_last_next   = (CNT_W'(rk_reg) == n_last);
            res_ccount_next = (CNT_W'(rk_reg) == n_last) ? clus_reg : '0;
            res_ovf_next    = ovf_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.command == CMD_LOAD)
                    begin
                        if (count_reg < CNT_W'(MAX_POINTS))
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        n_next       = count_reg;
                        i_next       = '0;
                        k_next       = '0;
                        row_next     = '0;
                        nb_next      = '0;
                        visited_next = '0;
                        pending_next = '0;
                        labeled_next = '0;
                        clus_next    = '0;
                        eps2_next    = cfg.eps_radius * cfg.eps_radius;
                        if (count_reg == '0)
                        begin
                            res_valid_next  = 1'b1;
                            res_idx_next    = '0;
                            res_label_next  = '0;
                            res_pvalid_next = 1'b0;
                            res_ccount_next = '0;
                            res_ovf_next    = ovf_reg;
                            res_last_next   = 1'b1;
                            ovf_next        = 1'b0;
                        end
                        else if (cfg.eps_radius == '0 || cfg.min_pts == '0)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_ADJ_LDI;
                        end
                    end
                end
            end
            S_ADJ_LDI:
            begin
                state_next = S_ADJ_GETI;
            end
            S_ADJ_GETI:
            begin
                pi_next    = st_rdata;
                j_next     = '0;
                state_next = S_ADJ_ISSUE;
            end
            S_ADJ_ISSUE:
            begin
                j_next = j_reg + CNT_W'(1);
                if (j_reg == n_last)
                begin
                    state_next = S_ADJ_DRAIN;
                end
            end
            S_ADJ_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    row_next = '0;
                    nb_next  = '0;
                    i_next   = i_reg + CNT_W'(1);
                    if (i_reg == n_last)
                    begin
                        i_next     = '0;
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_ADJ_LDI;
                    end
                end
            end
            S_SEED:
            begin
                if (i_reg == n_reg)
                begin
                    k_next     = '0;
                    state_next = S_OUT;
                end
                else if (visited_reg[i_idx])
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    visited_next = visited_reg | i_bit;
                    state_next   = S_SEED_CHK;
                end
            end
            S_SEED_CHK:
            begin
                if (adj_core)
                begin
                    newly_next   = (adj_row | i_bit) & ~labeled_reg;
                    labeled_next = labeled_reg | adj_row | i_bit;
                    pending_next = pending_reg | (adj_row & ~visited_reg);
                    state_next   = S_LABEL;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SEED;
                end
            end
            S_LABEL:
            begin
                if (newly_reg == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    newly_next[lab_waddr] = 1'b0;
                end
            end
            S_POP:
            begin
                if (pending_reg == '0)
                begin
                    clus_next  = clus_reg + CCOUNT_W'(1);
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SEED;
                end
                else
                begin
                    pending_next[pend_first] = 1'b0;
                    visited_next[pend_first] = 1'b1;
                    state_next               = S_POP_CHK;
                end
            end
            S_POP_CHK:
            begin
                if (adj_core)
                begin
                    newly_next   = adj_row & ~labeled_reg;
                    labeled_next = labeled_reg | adj_row;
                    pending_next = pending_reg | (adj_row & ~visited_reg);
                    state_next   = S_LABEL;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_OUT:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg == n_last)
                begin
                    state_next = S_OUT_TAIL;
                end
            end
            S_OUT_TAIL:
            begin
                // last beat is loaded into the result registers; empty the store
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            nb_reg        <= '0;
            visited_reg   <= '0;
            pending_reg   <= '0;
            labeled_reg   <= '0;
            newly_reg     <= '0;
            clus_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            rv_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            nb_reg        <= nb_next;
            visited_reg   <= visited_next;
            pending_reg   <= pending_next;
            labeled_reg   <= labeled_next;
            newly_reg     <= newly_next;
            clus_reg      <= clus_next;
            v1_reg        <= (state_reg == S_ADJ_ISSUE);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            rv_reg        <= (state_reg == S_OUT);
            res_valid_reg <= res_valid_next;
        end
    end

    assign px    = dx_reg * dx_reg;
    assign py    = dy_reg * dy_reg;
    assign pz    = dz_reg * dz_reg;
    assign pdvw  = dv_reg * $signed({1'b0, cfg.doppler_weight});
    assign pdvw2 = dvw_reg * dvw_reg;

    always_ff @(posedge clk)
    begin
        eps2_reg <= eps2_next;
        pi_reg   <= pi_next;
        rk_reg   <= k_reg[IDX_W-1:0];
        j1_reg   <= j_idx;
        j2_reg   <= j1_reg;
        j3_reg   <= j2_reg;
        j4_reg   <= j3_reg;
        j5_reg   <= j4_reg;
        // coordinate differences
        dx_reg   <= $signed({pi_reg[15], pi_reg[15:0]}) -
                    $signed({st_rdata[15], st_rdata[15:0]});
        dy_reg   <= $signed({pi_reg[31], pi_reg[31:16]}) -
                    $signed({st_rdata[31], st_rdata[31:16]});
        dz_reg   <= $signed({pi_reg[47], pi_reg[47:32]}) -
                    $signed({st_rdata[47], st_rdata[47:32]});
        dv_reg   <= $signed({pi_reg[63], pi_reg[63:48]}) -
                    $signed({st_rdata[63], st_rdata[63:48]});
        // squares and doppler scaling
        sx_reg   <= px[32:0];
        sy_reg   <= py[32:0];
        sz_reg   <= pz[32:0];
        dvw_reg  <= pdvw;
        // spatial sum and doppler square
        sum3_reg <= {2'b0, sx_reg} + {2'b0, sy_reg} + {2'b0, sz_reg};
        dvw2_reg <= pdvw2;
        // align spatial part to the doppler fraction and add
        tot_reg  <= {9'b0, sum3_reg, 16'b0} + dvw2_reg;

        res_idx_reg    <= res_idx_next;
        res_label_reg  <= res_label_next;
        res_pvalid_reg <= res_pvalid_next;
        res_ccount_reg <= res_ccount_next;
        res_ovf_reg    <= res_ovf_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid  = res_valid_reg;
    assign point_index   = res_idx_reg;
    assign cluster_label = res_label_reg;
    assign point_valid   = res_pvalid_reg;
    assign cluster_count = res_ccount_reg;
    assign overflowed    = res_ovf_reg;
    assign is_last       = res_last_reg;

endmodule

`default_nettype wire

// ----- sv/dbscan_point_cloud_4d_unit.sv -----
// ----------------------------------------------------------------------------
// dbscan_point_cloud_4d_unit
// Density clustering of up to MAX_POINTS 4D points (x, y, z, doppler).
//
//   channel   handshake             payload
//   command   start / busy          command, pos_x, pos_y, pos_z, radial_speed
//   result    result_valid strobe   point_index, cluster_label, point_valid,
//                                   cluster_count, overflowed, is_last
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Loads stream in at one per cycle through a two entry command queue while
// the queue is not full. A run builds the adjacency rows with the single
// distance pipeline, one pair per cycle, expands clusters point by point
// with label writes, then gives one beat per point. busy rises when the
// queue holds two commands; results cannot be held off. rst_n clears
// control state asynchronously; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dbscan_point_cloud_4d_unit #(
    parameter int MAX_POINTS = dbpc4d_pkg::POINTS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic                                    command,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0]   pos_x,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0]   pos_y,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0]   pos_z,
    input  wire logic signed [dbpc4d_pkg::COORD_W-1:0]   radial_speed,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic        [dbpc4d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [dbpc4d_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                         result_valid,
    output logic             [dbpc4d_pkg::IDX_OUT_W-1:0]  point_index,
    output logic signed      [dbpc4d_pkg::LABEL_W-1:0]    cluster_label,
    output logic                                         point_valid,
    output logic             [dbpc4d_pkg::CCOUNT_W-1:0]   cluster_count,
    output logic                                         overflowed,
    output logic                                         is_last
);

    import dbpc4d_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eps_radius     <= EPS_RST;
            cfg_reg.min_pts        <= MINS_RST;
            cfg_reg.doppler_weight <= WGT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EPS:  cfg_reg.eps_radius     <= cfg_data[EPS_W-1:0];
                REG_MINS: cfg_reg.min_pts        <= cfg_data[MINS_W-1:0];
                REG_WGT:  cfg_reg.doppler_weight <= cfg_data[WGT_W-1:0];
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    dbpc4d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .radial_speed (radial_speed),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    dbpc4d_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .point_index   (point_index),
        .cluster_label (cluster_label),
        .point_valid   (point_valid),
        .cluster_count (cluster_count),
        .overflowed    (overflowed),
        .is_last       (is_last)
    );

endmodule

`default_nettype wire

// ----- tb/dbscan_point_cloud_4d_unit_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbscan_point_cloud_4d_unit_check
// Watches the command, config and result channels of the clustering unit.
// Keeps its own copy of the point store and the registers, clusters the
// store on every run beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module dbscan_point_cloud_4d_unit_check
    import dbpc4d_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            command,
    input  logic signed [COORD_W-1:0]       pos_x,
    input  logic signed [COORD_W-1:0]       pos_y,
    input  logic signed [COORD_W-1:0]       pos_z,
    input  logic signed [COORD_W-1:0]       radial_speed,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic        [CFG_IDX_W-1:0]     cfg_index,
    input  logic        [CFG_DATA_W-1:0]    cfg_data,
    input  logic                            result_valid,
    input  logic        [IDX_OUT_W-1:0]     point_index,
    input  logic signed [LABEL_W-1:0]       cluster_label,
    input  logic                            point_valid,
    input  logic        [CCOUNT_W-1:0]      cluster_count,
    input  logic                            overflowed,
    input  logic                            is_last,
    output int                              errors,
    output int                              outstanding
);

    typedef struct {
        logic [IDX_OUT_W-1:0] idx;
        logic [LABEL_W-1:0]   label;
        logic                 pvalid;
        logic [CCOUNT_W-1:0]  count;
        logic                 ovf;
        logic                 last;
    } label_beat_t;

    label_beat_t        label_q[$];
    logic [63:0]        cloud[64];
    int                 cloud_size;
    logic               cloud_ovf;
    logic [EPS_W-1:0]   eps;
    logic [MINS_W-1:0]  mins;
    logic [WGT_W-1:0]   wgt;

    logic [63:0]        adj[64];
    int                 nbr[64];
    logic [LABEL_W-1:0] lab[64];
    logic [63:0]        seen;
    logic [63:0]        pend;
    logic [LABEL_W-1:0] cur_cluster;

    function automatic longint unsigned pair_dist(logic [63:0] a, logic [63:0] b);
        longint          d;
        longint unsigned acc;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'($signed(a[16*k +: 16])) - longint'($signed(b[16*k +: 16]));
            acc += longint'(d * d) << 16;
        end
        d = (longint'($signed(a[63:48])) - longint'($signed(b[63:48]))) * longint'(wgt);
        acc += d * d;
        return acc;
    endfunction

    function automatic bit core(int p);
        return nbr[p] + 1 >= int'(mins);
    endfunction

    // Label unlabeled neighbors of core point p, queue the unseen ones.
    function automatic void absorb(int p, int n);
        for (int q = 0; q < n; q++)
            if (adj[p][q] && lab[q] == NOISE_LABEL)
                lab[q] = cur_cluster;
        pend |= adj[p] & ~seen;
    endfunction

    function automatic void cluster_cloud();
        longint unsigned lim;
        int              n;
        int              p;
        label_beat_t     b;
        n = cloud_size;
        for (int i = 0; i < n; i++)
        begin
            lab[i] = NOISE_LABEL;
            adj[i] = '0;
            nbr[i] = 0;
        end
        seen = '0;
        pend = '0;
        cur_cluster = '0;
        if (eps != 0 && mins != 0)
        begin
            lim = (longint'(eps) * longint'(eps)) << 16;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    if (i != j && pair_dist(cloud[i], cloud[j]) <= lim)
                    begin
                        adj[i][j] = 1'b1;
                        nbr[i]++;
                    end
            for (int i = 0; i < n; i++)
            begin
                if (seen[i])
                    continue;
                seen[i] = 1'b1;
                if (!core(i))
                    continue;
                lab[i] = cur_cluster;
                absorb(i, n);
                while (pend != 0)
                begin
                    p = 0;
                    while (!pend[p])
                        p++;
                    pend[p] = 1'b0;
                    seen[p] = 1'b1;
                    if (core(p))
                        absorb(p, n);
                end
                cur_cluster = cur_cluster + 1'b1;
            end
        end
        if (n == 0)
        begin
            b = '{idx: '0, label: '0, pvalid: 1'b0, count: '0, ovf: cloud_ovf, last: 1'b1};
            label_q.insert(label_q.size(), b);
        end
        for (int i = 0; i < n; i++)
        begin
            b.idx    = IDX_OUT_W'(i);
            b.label  = lab[i];
            b.pvalid = 1'b1;
            b.last   = (i == n - 1);
            b.count  = b.last ? cur_cluster : '0;
            b.ovf    = cloud_ovf;
            label_q.insert(label_q.size(), b);
        end
        cloud_size = 0;
        cloud_ovf  = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        label_beat_t b;
        if (!rst_n)
        begin
            label_q.delete();
            cloud_size  = 0;
            cloud_ovf   = 1'b0;
            eps         = EPS_RST;
            mins        = MINS_RST;
            wgt         = WGT_RST;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (label_q.size() == 0)
                begin
                    $error("result beat with no expectation (point_index %0d)", point_index);
                    errors <= errors + 1;
                end
                else
                begin
                    b = label_q.pop_front();
                    if (point_index !== b.idx || cluster_label !== b.label ||
                        point_valid !== b.pvalid || cluster_count !== b.count ||
                        overflowed !== b.ovf || is_last !== b.last)
                        errors <= errors + 1;
                    if (point_index !== b.idx)
                        $error("point_index: expected %0d, actual %0d", b.idx, point_index);
                    if (cluster_label !== b.label)
                        $error("cluster_label: expected %0d, actual %0d",
                               $signed(b.label), cluster_label);
                    if (point_valid !== b.pvalid)
                        $error("point_valid: expected %0d, actual %0d", b.pvalid, point_valid);
                    if (cluster_count !== b.count)
                        $error("cluster_count: expected %0d, actual %0d",
                               b.count, cluster_count);
                    if (overflowed !== b.ovf)
                        $error("overflowed: expected %0d, actual %0d", b.ovf, overflowed);
                    if (is_last !== b.last)
                        $error("is_last: expected %0d, actual %0d", b.last, is_last);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_EPS:  eps  = cfg_data[EPS_W-1:0];
                    REG_MINS: mins = cfg_data[MINS_W-1:0];
                    REG_WGT:  wgt  = cfg_data[WGT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (command == CMD_RUN)
                    cluster_cloud();
                else if (cloud_size < 64)
                begin
                    cloud[cloud_size] = {radial_speed, pos_z, pos_y, pos_x};
                    cloud_size++;
                end
                else
                    cloud_ovf = 1'b1;
            end
            outstanding <= label_q.size();
        end
    end

endmodule

// ----- tb/dbscan_point_cloud_4d_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbscan_point_cloud_4d_unit_test
// Loads point clouds and runs clustering under several register settings,
// with random gaps on the command and config channels. The checker beside
// the unit predicts every label beat; this module makes stimulus and reports.
// ----------------------------------------------------------------------------
module dbscan_point_cloud_4d_unit_test;
    import dbpc4d_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        command;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   pos_z;
    logic signed [COORD_W-1:0]   radial_speed;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        result_valid;
    logic [IDX_OUT_W-1:0]        point_index;
    logic signed [LABEL_W-1:0]   cluster_label;
    logic                        point_valid;
    logic [CCOUNT_W-1:0]         cluster_count;
    logic                        overflowed;
    logic                        is_last;
    int                          errors;
    int                          outstanding;
    int                          sent;

    dbscan_point_cloud_4d_unit i_dut (.*);

    dbscan_point_cloud_4d_unit_check i_check (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("dbscan_point_cloud_4d_unit_test failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send(logic cmd, int x, int y, int z, int v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        pos_x        <= COORD_W'(x);
        pos_y        <= COORD_W'(y);
        pos_z        <= COORD_W'(z);
        radial_speed <= COORD_W'(v);
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    // Drop start and wait until every label beat has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        repeat (gap_len()) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int e, int m, int w);
        drain();
        write_reg(REG_EPS, e);
        write_reg(REG_MINS, m);
        write_reg(REG_WGT, w);
    endtask

    // Load n points scattered around a few centers, some of them wild.
    task automatic load_cloud(int n, int spread);
        int cx[4];
        int cy[4];
        int cz[4];
        int cv[4];
        int k;
        for (int c = 0; c < 4; c++)
        begin
            cx[c] = $urandom_range(32000) - 16000;
            cy[c] = $urandom_range(32000) - 16000;
            cz[c] = $urandom_range(32000) - 16000;
            cv[c] = $urandom_range(32000) - 16000;
        end
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(3);
            if ($urandom_range(99) < 15)
                send(CMD_LOAD, $urandom, $urandom, $urandom, $urandom);
            else
                send(CMD_LOAD, cx[k] + $urandom_range(2*spread) - spread,
                     cy[k] + $urandom_range(2*spread) - spread,
                     cz[k] + $urandom_range(2*spread) - spread,
                     cv[k] + $urandom_range(2*spread) - spread);
        end
    endtask

    initial
    begin
        int n;
        int r;
        sent         = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_LOAD;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        radial_speed = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_EPS;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a tight group, a far pair, field extremes.
        send(CMD_RUN, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            send(CMD_LOAD, 10 * i, -5 * i, 3 * i, i);
        send(CMD_LOAD, 32767, 32767, 32767, 32767);
        send(CMD_LOAD, -32768, -32768, -32768, -32768);
        send(CMD_LOAD, 32767, -32768, 0, -1);
        send(CMD_LOAD, 0, 0, 0, 0);
        send(CMD_RUN, 0, 0, 0, 0);

        set_regs(0, 1, 4095);
        send(CMD_LOAD, 0, 0, 0, 0);
        send(CMD_LOAD, 0, 0, 0, 0);
        send(CMD_RUN, 0, 0, 0, 0);
        set_regs(65535, 0, 0);
        send(CMD_LOAD, 1, 2, 3, 4);
        send(CMD_LOAD, 1, 2, 3, 4);
        send(CMD_RUN, 0, 0, 0, 0);
        set_regs(65535, 255, 4095);
        send(CMD_LOAD, -32768, 5, 5, 32767);
        send(CMD_LOAD, 32767, 5, 5, -32768);
        send(CMD_RUN, 0, 0, 0, 0);

        while (sent < 240)
        begin
            r = $urandom_range(99);
            if (r < 8)
                set_regs($urandom_range(65535), $urandom_range(255), $urandom_range(4095));
            else if (r < 40)
                set_regs($urandom_range(1024, 64), $urandom_range(6, 1), $urandom_range(512));
            r = $urandom_range(99);
            if (r < 4)
                n = 66;
            else if (r < 12)
                n = $urandom_range(40, 20);
            else
                n = $urandom_range(12);
            load_cloud(n, $urandom_range(400, 20));
            send(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
        end

        // Full store plus a dropped load, at the loosest radius.
        set_regs(65535, 1, 4095);
        load_cloud(65, 200);
        send(CMD_RUN, 0, 0, 0, 0);

        drain();
        if (errors == 0)
            $display("dbscan_point_cloud_4d_unit_test passed");
        else
            $display("dbscan_point_cloud_4d_unit_test failed");
        $finish;
    end

endmodule
